>>> rtl/core/brpc_pkg.sv
// Shared types and constants for the back-EMF ripple position counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package brpc_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int CUR_W      = 15;
    localparam int BEMF_W     = 12;
    localparam int HIST_W     = 8;
    localparam int HIST_DEPTH = 5;
    localparam int GAP_W      = 7;
    localparam int POS_W      = 15;
    localparam int AXIS_W     = 3;
    localparam int DIR_W      = 2;
    localparam int SHIFT_W    = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Stream payload widths (padded to whole bytes)
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 56;

    localparam logic [GAP_W-1:0]  GAP_MAX  = 7'd127;
    localparam logic [BEMF_W-1:0] BEMF_MAX = 12'd4095;
    localparam logic [POS_W-1:0]  POS_MAX  = 15'd32767;

    // Sample kind carried in tuser
    typedef enum logic {
        CMD_CURRENT = 1'b0,
        CMD_BEMF    = 1'b1
    } cmd_t;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_AXIS    = 3'd0,
        REG_MOVE_DIRECTION = 3'd1,
        REG_CURRENT_SHIFT  = 3'd2,
        REG_BEMF_SHIFT     = 3'd3,
        REG_MIN_GAP        = 3'd4
    } cfg_reg_t;

endpackage

>>> rtl/core/brpc_lowpass.sv
// First-order low-pass step: avg + floor((x - avg) / 2^shift), kept in range.
// Depends on brpc_pkg for the shift width.
`timescale 1ns / 1ps

module brpc_lowpass #(
    parameter int W = 12
) (
    input  logic [W-1:0]                 x,
    input  logic [W-1:0]                 avg,
    input  logic [brpc_pkg::SHIFT_W-1:0] shift,
    output logic [W-1:0]                 result
);
    import brpc_pkg::*;

    logic signed [W:0]   diff;
    logic signed [W:0]   step;
    logic signed [W+1:0] sum;

    // Take the difference, shift it arithmetically (floor), add it back
    always_comb
    begin
        diff = $signed({1'b0, x}) - $signed({1'b0, avg});
        step = diff >>> shift;
        sum  = $signed({2'b00, avg}) + $signed({step[W], step});
    end

    // Clamp to the unsigned range of the average
    always_comb
    begin
        if (sum[W+1])
            result = '0;
        else if (sum[W])
            result = '1;
        else
            result = sum[W-1:0];
    end

endmodule

>>> rtl/core/bemf_ripple_position_counter.sv
// Top level of the back-EMF ripple position counter: filters, ripple detector,
// gap counter and per-axis position registers. Depends on brpc_pkg, brpc_lowpass.
`timescale 1ns / 1ps

// Takes one sample word per cycle on the slave stream while the master keeps up
// (tuser selects current or back-EMF) and returns exactly one result word per
// sample on the master stream. Each word passes an input register and a result
// register: the result register takes the word from the input register when it
// is empty or the master side is ready, and all filter, slope, gap and position
// work is done combinationally between the two registers.
// Throughput is one word per cycle, set only by master-side back-pressure.
// Configuration writes on cfg_we/cfg_index/cfg_data must be made while no words
// are in flight. Positions exist for axes below NUM_AXES (the axis select is
// three bits); a selected axis at or above NUM_AXES reports position zero.
module bemf_ripple_position_counter #(
    parameter int NUM_AXES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] sample (signed)
    input  logic [brpc_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] command
    input  logic [brpc_pkg::IN_USER_W-1:0]      s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [14:0] filtered_current, [26:15] filtered_bemf, [27] ripple_seen,
    // [42:28] axis_position, [49:43] gap_count, [55:50] zero
    output logic [brpc_pkg::OUT_DATA_W-1:0]     m_tdata,

    input  logic                                cfg_we,
    input  logic [brpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [brpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import brpc_pkg::*;

    localparam int AXIS_SLOTS = (NUM_AXES < (1 << AXIS_W)) ? NUM_AXES : (1 << AXIS_W);
    localparam int IDX_W      = (AXIS_SLOTS > 1) ? $clog2(AXIS_SLOTS) : 1;
    localparam int PAD_W      = OUT_DATA_W - (CUR_W + BEMF_W + 1 + POS_W + GAP_W);

    // Configuration registers
    logic [AXIS_W-1:0]        active_axis_reg;
    logic signed [DIR_W-1:0]  move_direction_reg;
    logic [SHIFT_W-1:0]       current_shift_reg;
    logic [SHIFT_W-1:0]       bemf_shift_reg;
    logic [GAP_W-1:0]         min_gap_reg;

    // Input stage
    logic                     in_valid_reg;
    cmd_t                     in_cmd_reg;
    logic signed [SAMPLE_W-1:0] in_sample_reg;

    // Block state
    logic [CUR_W-1:0]         current_avg_reg;
    logic [BEMF_W-1:0]        bemf_avg_reg;
    logic [HIST_W-1:0]        hist_reg [HIST_DEPTH];
    logic [GAP_W-1:0]         gap_reg;
    logic [POS_W-1:0]         pos_reg [AXIS_SLOTS];

    // Result stage
    logic                     out_valid_reg;
    logic [CUR_W-1:0]         out_current_reg;
    logic [BEMF_W-1:0]        out_bemf_reg;
    logic                     out_seen_reg;
    logic [POS_W-1:0]         out_pos_reg;
    logic [GAP_W-1:0]         out_gap_reg;

    // Combinational next values
    logic                     advance;
    logic                     process;
    logic [CUR_W-1:0]         cur_x;
    logic [BEMF_W-1:0]        bemf_x;
    logic [CUR_W-1:0]         current_filt;
    logic [BEMF_W-1:0]        bemf_filt;
    logic [HIST_W-1:0]        new_top;
    logic [HIST_W:0]          mean_a_sum;
    logic [HIST_W:0]          mean_b_sum;
    logic signed [HIST_W-1:0] slope_a;
    logic signed [HIST_W-1:0] slope_b;
    logic                     is_min;
    logic                     ripple;
    logic                     axis_ok;
    logic [IDX_W-1:0]         axis_idx;
    logic [POS_W-1:0]         cur_pos;
    logic signed [POS_W+1:0]  pos_sum;
    logic [POS_W-1:0]         pos_step;
    logic [CUR_W-1:0]         current_avg_next;
    logic [BEMF_W-1:0]        bemf_avg_next;
    logic [GAP_W-1:0]         gap_next;
    logic                     seen_next;
    logic [POS_W-1:0]         pos_out_next;

    // Handshake: the input register refills whenever its word moves on
    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_gap_reg, out_pos_reg, out_seen_reg,
                       out_bemf_reg, out_current_reg};

    // Clamp the raw sample for each filter
    always_comb
    begin
        if (in_sample_reg[SAMPLE_W-1])
            cur_x = '0;
        else
            cur_x = in_sample_reg[CUR_W-1:0];

        if (in_sample_reg[SAMPLE_W-1])
            bemf_x = '0;
        else if (in_sample_reg[SAMPLE_W-2:BEMF_W] != '0)
            bemf_x = BEMF_MAX;
        else
            bemf_x = in_sample_reg[BEMF_W-1:0];
    end

    brpc_lowpass #(
        .W      (CUR_W)
    ) u_current_lp (
        .x      (cur_x),
        .avg    (current_avg_reg),
        .shift  (current_shift_reg),
        .result (current_filt)
    );

    brpc_lowpass #(
        .W      (BEMF_W)
    ) u_bemf_lp (
        .x      (bemf_x),
        .avg    (bemf_avg_reg),
        .shift  (bemf_shift_reg),
        .result (bemf_filt)
    );

    // Slopes over the shifted history: newest against the mean of the two before
    always_comb
    begin
        new_top    = bemf_filt[BEMF_W-1:BEMF_W-HIST_W];
        mean_a_sum = {1'b0, hist_reg[1]} + {1'b0, hist_reg[2]};
        mean_b_sum = {1'b0, hist_reg[3]} + {1'b0, hist_reg[4]};
        slope_a    = $signed(hist_reg[3] - mean_a_sum[HIST_W:1]);
        slope_b    = $signed(new_top - mean_b_sum[HIST_W:1]);
        is_min     = (slope_a < 0) && (slope_b > 0) && (slope_a < slope_b);
        ripple     = is_min && (gap_reg > min_gap_reg);
    end

    // Active axis position and its stepped, clamped value
    always_comb
    begin
        axis_ok  = ({{(32-AXIS_W){1'b0}}, active_axis_reg} < NUM_AXES);
        axis_idx = active_axis_reg[IDX_W-1:0];
        cur_pos  = axis_ok ? pos_reg[axis_idx] : '0;
        pos_sum  = $signed({2'b00, cur_pos})
                 + $signed({{(POS_W){move_direction_reg[DIR_W-1]}}, move_direction_reg});
        if (pos_sum[POS_W+1])
            pos_step = '0;
        else if (pos_sum[POS_W])
            pos_step = POS_MAX;
        else
            pos_step = pos_sum[POS_W-1:0];
    end

    // Select what this word changes
    always_comb
    begin
        current_avg_next = current_avg_reg;
        bemf_avg_next    = bemf_avg_reg;
        gap_next         = gap_reg;
        seen_next        = 1'b0;
        pos_out_next     = cur_pos;
        case (in_cmd_reg)
            CMD_CURRENT:
            begin
                current_avg_next = current_filt;
            end
            CMD_BEMF:
            begin
                bemf_avg_next = bemf_filt;
                if (ripple)
                begin
                    seen_next = 1'b1;
                    gap_next  = '0;
                    if (axis_ok)
                        pos_out_next = pos_step;
                end
                else if (gap_reg != GAP_MAX)
                begin
                    gap_next = gap_reg + 1'b1;
                end
            end
            default:
            begin
                current_avg_next = current_avg_reg;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_axis_reg    <= '0;
            move_direction_reg <= '0;
            current_shift_reg  <= SHIFT_W'(1);
            bemf_shift_reg     <= SHIFT_W'(1);
            min_gap_reg        <= GAP_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACTIVE_AXIS:    active_axis_reg    <= cfg_data[AXIS_W-1:0];
                REG_MOVE_DIRECTION: move_direction_reg <= $signed(cfg_data[DIR_W-1:0]);
                REG_CURRENT_SHIFT:  current_shift_reg  <= cfg_data[SHIFT_W-1:0];
                REG_BEMF_SHIFT:     bemf_shift_reg     <= cfg_data[SHIFT_W-1:0];
                REG_MIN_GAP:        min_gap_reg        <= cfg_data[GAP_W-1:0];
                default:            min_gap_reg        <= min_gap_reg;
            endcase
        end
    end

    // Input register: hold the word until the result stage can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg    <= cmd_t'(s_tuser[0]);
            in_sample_reg <= $signed(s_tdata[SAMPLE_W-1:0]);
        end
    end

    // Block state: advance on each processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_avg_reg <= '0;
            bemf_avg_reg    <= '0;
            gap_reg         <= '0;
            for (int i = 0; i < HIST_DEPTH; i++)
                hist_reg[i] <= '0;
            for (int i = 0; i < AXIS_SLOTS; i++)
                pos_reg[i] <= '0;
        end
        else if (process)
        begin
            current_avg_reg <= current_avg_next;
            bemf_avg_reg    <= bemf_avg_next;
            gap_reg         <= gap_next;
            if (in_cmd_reg == CMD_BEMF)
            begin
                for (int i = 0; i < HIST_DEPTH - 1; i++)
                    hist_reg[i] <= hist_reg[i+1];
                hist_reg[HIST_DEPTH-1] <= new_top;
            end
            if (seen_next && axis_ok)
                pos_reg[axis_idx] <= pos_step;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_current_reg <= current_avg_next;
            out_bemf_reg    <= bemf_avg_next;
            out_seen_reg    <= seen_next;
            out_pos_reg     <= pos_out_next;
            out_gap_reg     <= gap_next;
        end
    end

endmodule

>>> tb/sv/bemf_ripple_position_counter_test.sv
// Self-checking testbench for bemf_ripple_position_counter: streams current and back-EMF
// sample words with random idling on both sides and checks every result word against a
// behavioral model of the filters, slope detector, gap counter and axis positions.
`timescale 1ns / 1ps

module bemf_ripple_position_counter_test;
    import brpc_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 10;
    localparam int AXIS_COUNT    = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_IDLE      = 5;
    localparam int MAX_REPORTS   = 10;
    localparam int SMOKE_ROWS    = 25;
    localparam int PHASES        = 12;
    localparam int LONG_PHASE    = 170;

    // One result word, laid out as on m_tdata (filtered_current in the low bits)
    typedef struct packed {
        logic [GAP_W-1:0]  gap;
        logic [POS_W-1:0]  pos;
        logic              seen;
        logic [BEMF_W-1:0] bemf;
        logic [CUR_W-1:0]  cur;
    } result_t;

    localparam int WORD_W = $bits(result_t);

    // Directed row: sample word plus, where typed is set, the result read off by hand
    typedef struct packed {
        cmd_t                cmd;
        logic [SAMPLE_W-1:0] sample;
        logic                typed;
        logic [CUR_W-1:0]    cur;
        logic [BEMF_W-1:0]   bemf;
        logic                seen;
        logic [POS_W-1:0]    pos;
        logic [GAP_W-1:0]    gap;
    } smoke_row_t;

    // Rows run with the reset settings: shifts of 1, min_gap of 3, direction 0
    smoke_row_t smoke_rows [SMOKE_ROWS] = '{
        '{CMD_CURRENT, 16'h0000, 1'b1, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h8000, 1'b1, 15'd0,     12'd0,    1'b0, 15'd0, 7'd1},
        '{CMD_BEMF,    16'h7FFF, 1'b1, 15'd0,     12'd2047, 1'b0, 15'd0, 7'd2},
        '{CMD_CURRENT, 16'h8000, 1'b1, 15'd0,     12'd2047, 1'b0, 15'd0, 7'd2},
        '{CMD_CURRENT, 16'h7FFF, 1'b1, 15'd16383, 12'd2047, 1'b0, 15'd0, 7'd2},
        '{CMD_CURRENT, 16'hFFFF, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0FFF, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h1000, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0000, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_CURRENT, 16'h0001, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'hFFFF, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0BB8, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0BB8, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0BB8, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0BB8, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0320, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0320, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0BB8, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0BB8, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_CURRENT, 16'h4000, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0BB8, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0320, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0320, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0BB8, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0},
        '{CMD_BEMF,    16'h0BB8, 1'b0, 15'd0,     12'd0,    1'b0, 15'd0, 7'd0}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // [15:0] sample (signed)
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    // [0] command
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [14:0] filtered_current, [26:15] filtered_bemf, [27] ripple_seen,
    // [42:28] axis_position, [49:43] gap_count, [55:50] zero
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Model copy of the registers, at their reset values
    logic [AXIS_W-1:0]        cfg_axis       = '0;
    logic signed [DIR_W-1:0]  cfg_dir        = '0;
    logic [SHIFT_W-1:0]       cfg_cur_shift  = 3'd1;
    logic [SHIFT_W-1:0]       cfg_bemf_shift = 3'd1;
    logic [GAP_W-1:0]         cfg_min_gap    = 7'd3;

    // Model copy of the filter, history, gap and position state
    int                       cur_level  = 0;
    int                       bemf_level = 0;
    logic [HIST_W-1:0]        bemf_trail [HIST_DEPTH] = '{default: '0};
    logic [GAP_W-1:0]         gap_run    = '0;
    logic [POS_W-1:0]         axis_pos   [AXIS_COUNT] = '{default: '0};

    result_t                  pending_results [$];
    int                       mismatches  = 0;
    int                       words_seen  = 0;
    int                       cycle_count = 0;
    bit                       no_idle     = 1'b0;

    // Ripple-shaped back-EMF source for the random part
    int                       wave_base;
    int                       wave_amp;
    int                       wave_period;
    int                       wave_phase;

    bemf_ripple_position_counter #(
        .NUM_AXES (AXIS_COUNT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Advance the model by one sample word and return the result it yields
    function automatic result_t track_sample(cmd_t cmd, logic [SAMPLE_W-1:0] raw);
        int                      level;
        int                      pos_next;
        logic signed [HIST_W-1:0] slope_old;
        logic signed [HIST_W-1:0] slope_new;
        result_t                 word;
        word = '0;
        level = int'($signed(raw));
        if (level < 0)
            level = 0;
        if (cmd == CMD_CURRENT)
        begin
            cur_level = cur_level + ((level - cur_level) >>> cfg_cur_shift);
            if (cur_level < 0)
                cur_level = 0;
        end
        else
        begin
            if (level > int'(BEMF_MAX))
                level = int'(BEMF_MAX);
            bemf_level = bemf_level + ((level - bemf_level) >>> cfg_bemf_shift);
            if (bemf_level < 0)
                bemf_level = 0;
            if (bemf_level > int'(BEMF_MAX))
                bemf_level = int'(BEMF_MAX);

            // Shift the top 8 bits of the filtered value into the history
            for (int i = 0; i < HIST_DEPTH - 1; i++)
                bemf_trail[i] = bemf_trail[i + 1];
            bemf_trail[HIST_DEPTH - 1] = bemf_level[BEMF_W-1:BEMF_W-HIST_W];

            // Newest minus mean of the two before, wrapped to 8-bit signed
            slope_old = HIST_W'(int'(bemf_trail[2])
                                - (int'(bemf_trail[0]) + int'(bemf_trail[1])) / 2);
            slope_new = HIST_W'(int'(bemf_trail[4])
                                - (int'(bemf_trail[2]) + int'(bemf_trail[3])) / 2);

            // Count a local minimum only once the gap exceeds min_gap
            if (slope_old < 0 && slope_new > 0 && slope_old < slope_new
                && gap_run > cfg_min_gap)
            begin
                word.seen = 1'b1;
                gap_run = '0;
                pos_next = int'(axis_pos[cfg_axis]) + int'(cfg_dir);
                if (pos_next < 0)
                    pos_next = 0;
                if (pos_next > int'(POS_MAX))
                    pos_next = int'(POS_MAX);
                axis_pos[cfg_axis] = pos_next[POS_W-1:0];
            end
            else if (gap_run < GAP_MAX)
            begin
                gap_run = gap_run + 1'b1;
            end
        end
        word.cur  = cur_level[CUR_W-1:0];
        word.bemf = bemf_level[BEMF_W-1:0];
        word.pos  = axis_pos[cfg_axis];
        word.gap  = gap_run;
        return word;
    endfunction

    // Present one sample word after a random idle gap; hold it until taken
    task automatic send_word(input cmd_t cmd, input logic [SAMPLE_W-1:0] sample,
                             input logic typed, input result_t typed_word);
        int      idle;
        result_t predicted;
        idle = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
        if (idle > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = track_sample(cmd, sample);
        pending_results.push_back(typed ? typed_word : predicted);
    endtask

    // Drop valid and hold until every expected result word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write one register and mirror it into the model; caller lowers cfg_we
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_ACTIVE_AXIS:    cfg_axis       = value[AXIS_W-1:0];
            REG_MOVE_DIRECTION: cfg_dir        = value[DIR_W-1:0];
            REG_CURRENT_SHIFT:  cfg_cur_shift  = value[SHIFT_W-1:0];
            REG_BEMF_SHIFT:     cfg_bemf_shift = value[SHIFT_W-1:0];
            REG_MIN_GAP:        cfg_min_gap    = value[GAP_W-1:0];
            default:            ;
        endcase
        @(posedge clk);
    endtask

    // Take result words after random stalls and check them against the oldest expectation
    initial
    begin : result_sink
        int      stall;
        result_t want;
        result_t got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got = m_tdata[WORD_W-1:0];
            if (pending_results.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("word %0d: result word with no sample outstanding", words_seen);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.cur !== want.cur || got.bemf !== want.bemf || got.seen !== want.seen
                    || got.pos !== want.pos || got.gap !== want.gap
                    || m_tdata[OUT_DATA_W-1:WORD_W] !== '0)
                begin
                    if (mismatches < MAX_REPORTS)
                    begin
                        $display("word %0d: expected cur=%0d bemf=%0d ripple=%0d pos=%0d gap=%0d",
                                 words_seen, want.cur, want.bemf, want.seen, want.pos,
                                 want.gap);
                        $display("word %0d: got cur=%0d bemf=%0d ripple=%0d pos=%0d gap=%0d pad=%0h",
                                 words_seen, got.cur, got.bemf, got.seen, got.pos, got.gap,
                                 m_tdata[OUT_DATA_W-1:WORD_W]);
                    end
                    mismatches++;
                end
            end
            words_seen++;
        end
    end

    initial
    begin : stimulus
        int                   phase_len;
        int                   pick;
        int                   axis_val;
        int                   dir_bits;
        int                   cur_sh;
        int                   bemf_sh;
        int                   gap_min;
        int                   half;
        int                   span;
        int                   level;
        cmd_t                 cmd;
        logic [SAMPLE_W-1:0]  sample;
        logic [CFG_IDX_W-1:0] unused_index;
        result_t              typed_word;

        // Hold reset, then release it on a clock edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under the reset settings
        for (int i = 0; i < SMOKE_ROWS; i++)
        begin
            typed_word = {smoke_rows[i].gap, smoke_rows[i].pos, smoke_rows[i].seen,
                          smoke_rows[i].bemf, smoke_rows[i].cur};
            send_word(smoke_rows[i].cmd, smoke_rows[i].sample, smoke_rows[i].typed,
                      typed_word);
        end
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            // Pick settings: extremes first, then random ones
            case (p)
                0:
                begin
                    axis_val = 0; dir_bits = 1; cur_sh = 1; bemf_sh = 1; gap_min = 0;
                end
                1:
                begin
                    axis_val = 7; dir_bits = 3; cur_sh = 0; bemf_sh = 0; gap_min = 126;
                end
                2:
                begin
                    axis_val = 3; dir_bits = 2; cur_sh = 5; bemf_sh = 5; gap_min = 127;
                end
                3:
                begin
                    axis_val = 7; dir_bits = 1; cur_sh = 7; bemf_sh = 7; gap_min = 2;
                end
                4:
                begin
                    axis_val = 3; dir_bits = 3; cur_sh = 6; bemf_sh = 6; gap_min = 1;
                end
                5:
                begin
                    axis_val = 0; dir_bits = 0; cur_sh = 3; bemf_sh = 2; gap_min = 4;
                end
                default:
                begin
                    axis_val = $urandom_range(AXIS_COUNT - 1, 0);
                    dir_bits = $urandom_range(3, 0);
                    cur_sh   = ($urandom_range(5, 0) == 0) ? $urandom_range(7, 0)
                                                           : $urandom_range(5, 1);
                    bemf_sh  = ($urandom_range(5, 0) == 0) ? $urandom_range(7, 0)
                                                           : $urandom_range(5, 1);
                    gap_min  = ($urandom_range(3, 0) == 0) ? $urandom_range(127, 0)
                                                           : $urandom_range(8, 0);
                end
            endcase
            write_reg(REG_ACTIVE_AXIS, CFG_DATA_W'(axis_val));
            write_reg(REG_MOVE_DIRECTION, CFG_DATA_W'(dir_bits));
            write_reg(REG_CURRENT_SHIFT, CFG_DATA_W'(cur_sh));
            write_reg(REG_BEMF_SHIFT, CFG_DATA_W'(bemf_sh));
            write_reg(REG_MIN_GAP, CFG_DATA_W'(gap_min));
            // An index past the register list must change nothing
            unused_index = REG_MIN_GAP;
            unused_index = unused_index + CFG_IDX_W'($urandom_range(3, 1));
            write_reg(unused_index, CFG_DATA_W'($urandom()));
            cfg_we <= 1'b0;

            no_idle     = ($urandom_range(3, 0) == 0);
            wave_base   = $urandom_range(3400, 700);
            wave_amp    = $urandom_range(600, 64);
            wave_period = $urandom_range(30, 6);
            wave_phase  = 0;
            phase_len   = (p == 1 || p == 2) ? LONG_PHASE : $urandom_range(130, 80);

            for (int n = 0; n < phase_len; n++)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                begin
                    // Triangle ripple with its dip mid-period, plus a little noise
                    cmd   = CMD_BEMF;
                    half  = wave_period / 2;
                    span  = (wave_phase < half) ? half - wave_phase : wave_phase - half;
                    level = wave_base - wave_amp + (2 * wave_amp * span) / half
                            + int'($urandom_range(15, 0));
                    if (level > int'(BEMF_MAX))
                        level = int'(BEMF_MAX);
                    sample     = SAMPLE_W'(level);
                    wave_phase = (wave_phase + 1) % wave_period;
                end
                else if (pick < 85)
                begin
                    cmd = CMD_CURRENT;
                    if ($urandom_range(7, 0) == 0)
                    begin
                        case ($urandom_range(3, 0))
                            0:       sample = 16'h7FFF;
                            1:       sample = 16'h8000;
                            2:       sample = 16'h0000;
                            default: sample = 16'hFFFF;
                        endcase
                    end
                    else
                    begin
                        sample = SAMPLE_W'($urandom());
                    end
                end
                else if (pick < 93)
                begin
                    // Noise over the whole signed range, mostly out of the valid band
                    cmd    = CMD_BEMF;
                    sample = SAMPLE_W'($urandom());
                end
                else
                begin
                    cmd    = CMD_BEMF;
                    sample = SAMPLE_W'($urandom_range(int'(BEMF_MAX), 0));
                end
                send_word(cmd, sample, 1'b0, '0);
            end
            drain_results();
        end

        // Let any stray word surface before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
